// ----- rtl/brfle_pkg.sv -----
// ----------------------------------------------------------------------------
// brfle_pkg
// Shared constants, types and helpers of the byte ring FIFO with line extract.
// ----------------------------------------------------------------------------
package brfle_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int MAX_BURST   = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEVEL_W     = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W       = ADDR_W + 1;
   localparam int DATA_W      = 8;
   localparam int KIND_W      = 2;
   localparam int COUNT_W     = 7;
   localparam int OFFSET_W    = 10;
   localparam int LEN_W       = 6;

   localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_LINE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_PK_ADDR,
      ST_PK_DATA,
      ST_LN_ADDR,
      ST_LN_DATA,
      ST_LN_NONE
   } state_type;

   typedef struct packed {
      logic load;
      logic write_emit;
      logic rd_issue;
      logic pop_emit;
      logic peek_issue;
      logic peek_emit;
      logic scan_issue;
      logic scan_next;
      logic line_start;
      logic none_emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic burst_last;
      logic scan_done;
      logic newline;
   } status_type;

   // pos + step, wrapped once at the capacity
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0]  pos,
                                                  input logic [SUM_W-1:0]   step,
                                                  input logic [LEVEL_W-1:0] cap);
      logic [SUM_W:0] sum;
      sum = {2'b00, pos} + {1'b0, step};
      if (sum >= (SUM_W + 1)'(cap)) begin
         sum = sum - (SUM_W + 1)'(cap);
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      r = c;
      if (c == '0) begin
         r = COUNT_W'(1);
      end else if (c > COUNT_W'(MAX_BURST)) begin
         r = COUNT_W'(MAX_BURST);
      end
      return r;
   endfunction

   function automatic logic [LEVEL_W-1:0] clamp_capacity(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = LEVEL_W'(1);
      end else if (v > LEVEL_W'(STORE_DEPTH)) begin
         r = LEVEL_W'(STORE_DEPTH);
      end
      return r;
   endfunction

endpackage

// ----- rtl/byte_ring_fifo_with_line_extract_unit.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_line_extract_unit
// Byte ring FIFO with write, burst read, peek and readline requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per handshake (valid/stall). req_kind selects write,
//            read of req_count bytes, peek at req_offset, or readline with
//            buffer size req_count.
//   rsp_*  : one response per byte/result (valid/stall); rsp_last marks the
//            final response of a request, rsp_fill_level the level after it.
//   csr_*  : capacity write (valid/ready, always ready); empties the FIFO.
// Timing:
//   write : response register loaded at acceptance; back-to-back writes run at
//           one per cycle while the response register drains.
//   read  : per byte a store read, then a pop once the response register frees.
//   peek  : a store read, then the response.
//   line  : per scanned byte a store read and newline check, then per line
//           byte a store read and a pop, or one response when none is found.
//   The byte store's registered read port splits each byte into these steps.
// Reset clears the pointers and fill level and sets capacity to the full
// store. A stalled response holds; a new response waits for the register to
// free, and requests are stalled meanwhile.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_line_extract_unit
   import brfle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [DATA_W-1:0]   req_data_in,
   input  logic [COUNT_W-1:0]  req_count,
   input  logic [OFFSET_W-1:0] req_offset,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_data_out,
   output logic                rsp_accepted,
   output logic [LEN_W-1:0]    rsp_line_length,
   output logic                rsp_last,
   output logic [LEVEL_W-1:0]  rsp_fill_level,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEVEL_W-1:0]  csr_capacity
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   brfle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .kind      (kind_type'(req_kind)),
      .status    (status),
      .cmd       (cmd)
   );

   brfle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data_in     (req_data_in),
      .req_count       (req_count),
      .req_offset      (req_offset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_capacity    (csr_capacity),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_accepted    (rsp_accepted),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .rsp_fill_level  (rsp_fill_level)
   );

endmodule

// ----- rtl/brfle_ram.sv -----
// ----------------------------------------------------------------------------
// brfle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brfle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/brfle_ctrl.sv -----
// ----------------------------------------------------------------------------
// brfle_ctrl
// Sequencer: accepts one request at a time and steps the datapath through
// writes, burst reads, peeks and the newline scan / line pop.
// ----------------------------------------------------------------------------
module brfle_ctrl
   import brfle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  kind_type   kind,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && req_valid && status.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_WRITE: state_in = ST_IDLE;
                  KIND_READ:  state_in = ST_RD_ADDR;
                  KIND_PEEK:  state_in = ST_PK_ADDR;
                  KIND_LINE:  state_in = ST_LN_ADDR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            if (status.out_free) begin
               state_in = status.burst_last ? ST_IDLE : ST_RD_ADDR;
            end
         end
         ST_PK_ADDR: state_in = ST_PK_DATA;
         ST_PK_DATA: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LN_ADDR: state_in = status.scan_done ? ST_LN_NONE : ST_LN_DATA;
         ST_LN_DATA: state_in = status.newline ? ST_RD_ADDR : ST_LN_ADDR;
         ST_LN_NONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = !status.out_free;
            cmd.load       = accept;
            cmd.write_emit = accept && (kind == KIND_WRITE);
         end
         ST_RD_ADDR: cmd.rd_issue   = 1'b1;
         ST_RD_DATA: cmd.pop_emit   = status.out_free;
         ST_PK_ADDR: cmd.peek_issue = 1'b1;
         ST_PK_DATA: cmd.peek_emit  = status.out_free;
         ST_LN_ADDR: cmd.scan_issue = !status.scan_done;
         ST_LN_DATA: begin
            cmd.line_start = status.newline;
            cmd.scan_next  = !status.newline;
         end
         ST_LN_NONE: cmd.none_emit  = status.out_free;
         default:    cmd            = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/brfle_dp.sv -----
// ----------------------------------------------------------------------------
// brfle_dp
// Datapath: ring pointers, fill level, capacity register, byte store and the
// response register.
// ----------------------------------------------------------------------------
module brfle_dp
   import brfle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [DATA_W-1:0]   req_data_in,
   input  logic [COUNT_W-1:0]  req_count,
   input  logic [OFFSET_W-1:0] req_offset,
   input  logic                csr_valid,
   input  logic [LEVEL_W-1:0]  csr_capacity,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_data_out,
   output logic                rsp_accepted,
   output logic [LEN_W-1:0]    rsp_line_length,
   output logic                rsp_last,
   output logic [LEVEL_W-1:0]  rsp_fill_level
);

   logic [LEVEL_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0]   rp_ff, rp_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [LEVEL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0]  beat_ff, beat_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                line_ff, line_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [LEVEL_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic                ram_we;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [DATA_W-1:0]   ram_rdata;
   logic                has_room;
   logic                not_empty;
   logic [ADDR_W-1:0]   rp_inc;
   logic [ADDR_W-1:0]   wp_inc;

   assign has_room  = fill_ff < cap_ff;
   assign not_empty = fill_ff != '0;
   assign rp_inc    = ring_add(rp_ff, SUM_W'(1), cap_ff);
   assign wp_inc    = ring_add(wp_ff, SUM_W'(1), cap_ff);

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.burst_last = (beat_ff == cnt_ff - COUNT_W'(1));
   assign status.scan_done  = (idx_ff >= cnt_ff - COUNT_W'(1)) ||
                              (LEVEL_W'(idx_ff) >= fill_ff);
   assign status.newline    = (ram_rdata == NEWLINE_BYTE);

   assign ram_we = cmd.write_emit && has_room;
   assign ram_re = cmd.rd_issue || cmd.peek_issue || cmd.scan_issue;

   always_comb begin
      ram_raddr = rp_ff;
      if (cmd.peek_issue) begin
         ram_raddr = ring_add(rp_ff, SUM_W'(off_ff), cap_ff);
      end else if (cmd.scan_issue) begin
         ram_raddr = ring_add(rp_ff, SUM_W'(idx_ff), cap_ff);
      end
   end

   always_comb begin
      cap_in       = cap_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      beat_in      = beat_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      line_in      = line_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fill_in  = rsp_fill_ff;

      if (cmd.load) begin
         cnt_in  = clamp_count(req_count);
         off_in  = req_offset;
         idx_in  = '0;
         beat_in = '0;
         len_in  = '0;
         line_in = 1'b0;
      end

      if (cmd.write_emit) begin
         if (has_room) begin
            wp_in   = wp_inc;
            fill_in = fill_ff + LEVEL_W'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_acc_in   = has_room;
         rsp_len_in   = '0;
         rsp_last_in  = 1'b1;
         rsp_fill_in  = has_room ? fill_ff + LEVEL_W'(1) : fill_ff;
      end

      if (cmd.pop_emit) begin
         if (not_empty) begin
            rp_in   = rp_inc;
            fill_in = fill_ff - LEVEL_W'(1);
         end
         beat_in      = beat_ff + COUNT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_data_in  = not_empty ? ram_rdata : '0;
         rsp_acc_in   = 1'b0;
         rsp_len_in   = line_ff ? len_ff : '0;
         rsp_last_in  = status.burst_last;
         rsp_fill_in  = not_empty ? fill_ff - LEVEL_W'(1) : fill_ff;
      end

      if (cmd.peek_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (LEVEL_W'(off_ff) < fill_ff) ? ram_rdata : '0;
         rsp_acc_in   = 1'b0;
         rsp_len_in   = '0;
         rsp_last_in  = 1'b1;
         rsp_fill_in  = fill_ff;
      end

      if (cmd.scan_next) begin
         idx_in = idx_ff + COUNT_W'(1);
      end

      if (cmd.line_start) begin
         cnt_in  = idx_ff + COUNT_W'(1);
         len_in  = LEN_W'(idx_ff + COUNT_W'(1));
         line_in = 1'b1;
         beat_in = '0;
      end

      if (cmd.none_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_acc_in   = 1'b0;
         rsp_len_in   = '0;
         rsp_last_in  = 1'b1;
         rsp_fill_in  = fill_ff;
      end

      // new capacity restarts the FIFO empty
      if (csr_valid) begin
         cap_in  = clamp_capacity(csr_capacity);
         rp_in   = '0;
         wp_in   = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= LEVEL_W'(STORE_DEPTH);
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      beat_ff     <= beat_in;
      off_ff      <= off_in;
      len_ff      <= len_in;
      line_ff     <= line_in;
      rsp_data_ff <= rsp_data_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   brfle_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (req_data_in),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_fill_level  = rsp_fill_ff;

endmodule

// ----- verif/byte_ring_fifo_with_line_extract_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_line_extract_unit_tb
// Checks the byte ring FIFO against a cycle-free behavioral predictor.
// Directed tests cover byte writes, burst reads, peeks, readline, count
// clamping, capacity limits and one long response hold-off; random traffic
// runs under several capacities with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_line_extract_unit_tb;
   import brfle_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]  data_out;
      logic               accepted;
      logic [LEN_W-1:0]   line_length;
      logic               last;
      logic [LEVEL_W-1:0] fill_level;
   } fifo_rsp_type;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind     = '0;
   logic [DATA_W-1:0]   req_data_in  = '0;
   logic [COUNT_W-1:0]  req_count    = '0;
   logic [OFFSET_W-1:0] req_offset   = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic [DATA_W-1:0]   rsp_data_out;
   logic                rsp_accepted;
   logic [LEN_W-1:0]    rsp_line_length;
   logic                rsp_last;
   logic [LEVEL_W-1:0]  rsp_fill_level;
   logic                csr_valid    = 1'b0;
   logic                csr_ready;
   logic [LEVEL_W-1:0]  csr_capacity = '0;

   // predicted FIFO state
   logic [DATA_W-1:0] fifo_bytes [STORE_DEPTH];
   int unsigned       fifo_rd;
   int unsigned       fifo_wr;
   int unsigned       fifo_fill;
   int unsigned       fifo_cap;
   fifo_rsp_type      pending_rsp_q[$];
   fifo_rsp_type      want_rsp;

   int unsigned mismatches = 0;
   bit          gaps_on    = 1'b0;
   bit          stall_on   = 1'b0;
   int          hold_left  = 0;
   int          burst_left = 0;

   byte_ring_fifo_with_line_extract_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_in     (req_data_in),
      .req_count       (req_count),
      .req_offset      (req_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_accepted    (rsp_accepted),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .rsp_fill_level  (rsp_fill_level),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("byte_ring_fifo_with_line_extract_unit test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void push_rsp(logic [DATA_W-1:0] data, logic acc,
                                    int unsigned len, logic last);
      fifo_rsp_type r;
      r.data_out    = data;
      r.accepted    = acc;
      r.line_length = LEN_W'(len);
      r.last        = last;
      r.fill_level  = LEVEL_W'(fifo_fill);
      pending_rsp_q.push_back(r);
   endfunction

   function automatic logic [DATA_W-1:0] fifo_peek(int unsigned ofs);
      int unsigned p;
      if (ofs >= fifo_fill) begin
         return '0;
      end
      p = fifo_rd + ofs;
      if (p >= fifo_cap) begin
         p = p - fifo_cap;
      end
      return fifo_bytes[p];
   endfunction

   function automatic logic [DATA_W-1:0] fifo_pop();
      logic [DATA_W-1:0] b;
      if (fifo_fill == 0) begin
         return '0;
      end
      b = fifo_bytes[fifo_rd];
      fifo_rd++;
      if (fifo_rd >= fifo_cap) begin
         fifo_rd = 0;
      end
      fifo_fill--;
      return b;
   endfunction

   function automatic void predict_request(kind_type kind, logic [DATA_W-1:0] data,
                                           logic [COUNT_W-1:0] count,
                                           logic [OFFSET_W-1:0] offset);
      int unsigned n;
      int unsigned scan;
      int unsigned len;
      logic [DATA_W-1:0] b;
      n = count;
      if (n < 1) begin
         n = 1;
      end
      if (n > MAX_BURST) begin
         n = MAX_BURST;
      end
      case (kind)
         KIND_WRITE: begin
            if (fifo_fill < fifo_cap) begin
               fifo_bytes[fifo_wr] = data;
               fifo_wr++;
               if (fifo_wr >= fifo_cap) begin
                  fifo_wr = 0;
               end
               fifo_fill++;
               push_rsp('0, 1'b1, 0, 1'b1);
            end else begin
               push_rsp('0, 1'b0, 0, 1'b1);
            end
         end
         KIND_READ: begin
            for (int i = 0; i < n; i++) begin
               b = fifo_pop();
               push_rsp(b, 1'b0, 0, i + 1 == n);
            end
         end
         KIND_PEEK: begin
            push_rsp(fifo_peek(offset), 1'b0, 0, 1'b1);
         end
         default: begin
            scan = n - 1;
            if (fifo_fill < scan) begin
               scan = fifo_fill;
            end
            len = 0;
            for (int i = 0; i < scan && len == 0; i++) begin
               if (fifo_peek(i) == NEWLINE_BYTE) begin
                  len = i + 1;
               end
            end
            if (len == 0) begin
               push_rsp('0, 1'b0, 0, 1'b1);
            end else begin
               for (int k = 0; k < len; k++) begin
                  b = fifo_pop();
                  push_rsp(b, 1'b0, len, k + 1 == len);
               end
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response: expected none, actual data %0d last %0d",
                     $time, rsp_data_out, rsp_last);
         end else begin
            want_rsp = pending_rsp_q.pop_front();
            check_field("data_out", want_rsp.data_out, rsp_data_out);
            check_field("accepted", want_rsp.accepted, rsp_accepted);
            check_field("line_length", want_rsp.line_length, rsp_line_length);
            check_field("last", want_rsp.last, rsp_last);
            check_field("fill_level", want_rsp.fill_level, rsp_fill_level);
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_request(kind_type kind, logic [DATA_W-1:0] data,
                               logic [COUNT_W-1:0] count, logic [OFFSET_W-1:0] offset);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_data_in <= data;
      req_count   <= count;
      req_offset  <= offset;
      do @(posedge clock); while (req_stall);
      predict_request(kind, data, count, offset);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   task automatic write_capacity(logic [LEVEL_W-1:0] value);
      int unsigned v;
      wait_idle();
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      v = value;
      if (v < 1) begin
         v = 1;
      end
      if (v > STORE_DEPTH) begin
         v = STORE_DEPTH;
      end
      fifo_cap  = v;
      fifo_rd   = 0;
      fifo_wr   = 0;
      fifo_fill = 0;
   endtask

   function automatic logic [DATA_W-1:0] plain_byte();
      logic [DATA_W-1:0] b;
      b = DATA_W'($urandom_range(0, 254));
      if (b >= NEWLINE_BYTE) begin
         b = b + 1'b1;
      end
      return b;
   endfunction

   task automatic write_line(int len);
      for (int i = 0; i < len - 1; i++) begin
         send_request(KIND_WRITE, plain_byte(), '0, '0);
      end
      send_request(KIND_WRITE, NEWLINE_BYTE, '0, '0);
   endtask

   task automatic drain_fifo();
      while (fifo_fill > 0) send_request(KIND_READ, '0, COUNT_W'(MAX_BURST), '0);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return COUNT_W'($urandom_range(0, 127));
         1, 2: return COUNT_W'(MAX_BURST);
         default: return COUNT_W'($urandom_range(1, 16));
      endcase
   endfunction

   task automatic send_random_request();
      kind_type            kind;
      logic [DATA_W-1:0]   data;
      logic [COUNT_W-1:0]  count;
      logic [OFFSET_W-1:0] offset;
      int unsigned         pick;
      pick   = $urandom_range(0, 99);
      data   = DATA_W'($urandom_range(0, 255));
      count  = COUNT_W'($urandom_range(0, 127));
      offset = OFFSET_W'($urandom_range(0, 1023));
      if (pick < 45) begin
         kind = KIND_WRITE;
         if ($urandom_range(0, 5) == 0) begin
            data = NEWLINE_BYTE;
         end
      end else if (pick < 60) begin
         kind  = KIND_READ;
         count = pick_count();
      end else if (pick < 72) begin
         kind = KIND_PEEK;
         if ($urandom_range(0, 3) != 0) begin
            offset = OFFSET_W'($urandom_range(0, fifo_fill + 1));
         end
      end else begin
         kind  = KIND_LINE;
         count = pick_count();
      end
      send_request(kind, data, count, offset);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_write_read();
      send_request(KIND_WRITE, 8'h00, '0, '0);
      send_request(KIND_WRITE, 8'hFF, '0, '0);
      send_request(KIND_WRITE, NEWLINE_BYTE, '0, '0);
      send_request(KIND_WRITE, 8'h5A, '0, '0);
      send_request(KIND_READ, '0, 7'd2, '0);
      send_request(KIND_READ, '0, 7'd0, '0);
      send_request(KIND_READ, '0, 7'd127, '0);
      send_request(KIND_READ, '0, 7'd1, '0);
   endtask

   task automatic test_peek();
      send_request(KIND_WRITE, 8'h11, '0, '0);
      send_request(KIND_WRITE, 8'h22, '0, '0);
      send_request(KIND_WRITE, 8'h33, '0, '0);
      send_request(KIND_PEEK, 8'hFF, 7'h7F, 10'd0);
      send_request(KIND_PEEK, '0, '0, 10'd2);
      send_request(KIND_PEEK, '0, '0, 10'd3);
      send_request(KIND_PEEK, '0, '0, 10'd1023);
      drain_fifo();
   endtask

   task automatic test_readline();
      write_line(3);
      send_request(KIND_LINE, '0, 7'd64, '0);
      send_request(KIND_WRITE, 8'h61, '0, '0);
      send_request(KIND_WRITE, 8'h62, '0, '0);
      send_request(KIND_LINE, '0, 7'd64, '0);
      send_request(KIND_WRITE, NEWLINE_BYTE, '0, '0);
      // newline just past the scan window, then just inside it
      send_request(KIND_LINE, '0, 7'd3, '0);
      send_request(KIND_LINE, '0, 7'd4, '0);
      send_request(KIND_LINE, '0, 7'd1, '0);
      send_request(KIND_LINE, '0, 7'd0, '0);
      write_line(63);
      send_request(KIND_LINE, '0, 7'd63, '0);
      send_request(KIND_LINE, '0, 7'd100, '0);
      send_request(KIND_LINE, '0, 7'd64, '0);
   endtask

   task automatic test_capacity();
      write_capacity(11'd0);
      send_request(KIND_WRITE, 8'hA5, '0, '0);
      send_request(KIND_WRITE, 8'h5A, '0, '0);
      send_request(KIND_PEEK, '0, '0, 10'd0);
      send_request(KIND_READ, '0, 7'd2, '0);
      write_capacity(11'd2047);
      for (int i = 0; i < 6; i++) begin
         send_request(KIND_WRITE, (i == 3) ? NEWLINE_BYTE : plain_byte(), '0, '0);
      end
      send_request(KIND_PEEK, '0, '0, 10'd1023);
      send_request(KIND_LINE, '0, 7'd64, '0);
      drain_fifo();
      write_capacity(11'd3);
      for (int i = 0; i < 4; i++) begin
         send_request(KIND_WRITE, plain_byte(), '0, '0);
         send_request(KIND_WRITE, NEWLINE_BYTE, '0, '0);
         send_request(KIND_WRITE, plain_byte(), '0, '0);
         send_request(KIND_WRITE, plain_byte(), '0, '0);
         send_request(KIND_PEEK, '0, '0, OFFSET_W'(i % 4));
         send_request(KIND_LINE, '0, 7'd64, '0);
         send_request(KIND_READ, '0, 7'd1, '0);
      end
      write_capacity(11'd1);
      send_request(KIND_WRITE, NEWLINE_BYTE, '0, '0);
      send_request(KIND_LINE, '0, 7'd64, '0);
      write_capacity(11'd1024);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_left = 200;
      for (int i = 0; i < 12; i++) begin
         send_request(KIND_WRITE, (i % 4 == 3) ? NEWLINE_BYTE : plain_byte(), '0, '0);
      end
      send_request(KIND_READ, '0, 7'd5, '0);
      send_request(KIND_LINE, '0, 7'd64, '0);
      send_request(KIND_PEEK, '0, '0, 10'd1);
      drain_fifo();
   endtask

   task automatic test_random_traffic(logic [LEVEL_W-1:0] cap, int items);
      write_capacity(cap);
      for (int i = 0; i < items; i++) begin
         send_random_request();
      end
   endtask

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         fifo_bytes[i] = '0;
      end
      fifo_rd   = 0;
      fifo_wr   = 0;
      fifo_fill = 0;
      fifo_cap  = STORE_DEPTH;
      repeat (9) @(posedge clock);
      reset    <= 1'b0;
      gaps_on  = 1'b1;
      stall_on = 1'b1;

      test_write_read();
      test_peek();
      test_readline();
      test_capacity();
      test_backpressure();
      test_random_traffic(11'd16, 10);
      test_random_traffic(11'd5, 10);
      test_random_traffic(11'd1024, 10);
      test_random_traffic(11'd1, 10);
      wait_idle();
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      test_random_traffic(11'd200, 20);

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("byte_ring_fifo_with_line_extract_unit test passed");
      end else begin
         $display("byte_ring_fifo_with_line_extract_unit test failed");
      end
      $finish;
   end

endmodule
